@@ rtl/bfsa_pkg.sv @@
// Shared codes, field widths and result type for the best-fit segment allocator.
package bfsa_pkg;

    localparam int POOL_W   = 17;
    localparam int REQ_W    = 17;
    localparam int FADDR_W  = 16;
    localparam int GRANT_W  = 16;
    localparam int STATUS_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

    localparam logic [POOL_W-1:0] POOL_RESET = 17'd65536;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted;
    } t_result;

endpackage

@@ rtl/best_fit_segment_allocator_top.sv @@
// Best-fit segment allocator: the segment table, the scan sequencer and the result register.
// For each word, allocate or free, the sequencer reads the whole segment table through the
// single read port of the table memory, one entry a cycle, then writes back one entry, or two
// when an allocation splits a segment, or none when the request fails, before the result is
// loaded into the output register. One word is in work at a time; a finished result waits in
// the output register while the next word is taken. After reset, and after every pool_size
// write, the S_INIT state re-initializes the table to a single free segment covering
// min(pool_size, 2^ADDRESS_BITS) units.
module best_fit_segment_allocator_top import bfsa_pkg::*; #(
    parameter int SEGMENTS     = 64,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [POOL_W-1:0]    i_pool_size,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [REQ_W-1:0]     i_request_size,
    input  logic [FADDR_W-1:0]   i_free_address,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [GRANT_W-1:0]   o_granted_address
);

    localparam int IW = $clog2(SEGMENTS);
    localparam int EW = 2 * ADDRESS_BITS + 2;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic          rd_valid;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_set_valid;
    logic          init;
    logic          push;
    logic          res_ready;
    t_result       res;

    logic    r_out_valid;
    t_result r_out;

    bfsa_table #(
        .SEGMENTS     (SEGMENTS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (rd_en),
        .i_rd_addr      (rd_addr),
        .o_rd_data      (rd_data),
        .o_rd_valid     (rd_valid),
        .i_wr_en        (wr_en),
        .i_wr_addr      (wr_addr),
        .i_wr_data      (wr_data),
        .i_wr_set_valid (wr_set_valid),
        .i_init         (init)
    );

    bfsa_ctrl #(
        .SEGMENTS     (SEGMENTS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_pool_size    (i_pool_size),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .i_rd_valid     (rd_valid),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_wr_set_valid (wr_set_valid),
        .o_init         (init),
        .o_push         (push),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // slot is free when empty or drained this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_granted_address = r_out.granted;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten before it was taken");

endmodule

@@ rtl/bfsa_table.sv @@
// Segment table memory with per-entry valid bits.
module bfsa_table import bfsa_pkg::*; #(
    parameter int SEGMENTS     = 64,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rd_en,
    input  logic [$clog2(SEGMENTS)-1:0]          i_rd_addr,
    output logic [2*ADDRESS_BITS+1:0]            o_rd_data,
    output logic                                 o_rd_valid,
    input  logic                                 i_wr_en,
    input  logic [$clog2(SEGMENTS)-1:0]          i_wr_addr,
    input  logic [2*ADDRESS_BITS+1:0]            i_wr_data,
    input  logic                                 i_wr_set_valid,
    input  logic                                 i_init
);

    localparam int EW = 2 * ADDRESS_BITS + 2;

    logic [EW-1:0]       r_mem [SEGMENTS];
    logic [SEGMENTS-1:0] r_valid;
    logic [EW-1:0]       r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= SEGMENTS'(1);
            r_rd_valid <= 1'b0;
        end else begin
            if (i_init) begin
                r_valid <= SEGMENTS'(1);
            end else if (i_wr_en && i_wr_set_valid) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

    // a new used segment must land in a slot that was free
    a_spare_was_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en && i_wr_set_valid && !i_init |-> !r_valid[i_wr_addr])
        else $error("spare write hit a valid entry");

endmodule

@@ rtl/bfsa_ctrl.sv @@
// Scan sequencer: best-fit search, lookup for free, table write-back and table init.
module bfsa_ctrl import bfsa_pkg::*; #(
    parameter int SEGMENTS     = 64,
    parameter int ADDRESS_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [POOL_W-1:0]           i_pool_size,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [REQ_W-1:0]            i_request_size,
    input  logic [FADDR_W-1:0]          i_free_address,
    output logic                        o_rd_en,
    output logic [$clog2(SEGMENTS)-1:0] o_rd_addr,
    input  logic [2*ADDRESS_BITS+1:0]   i_rd_data,
    input  logic                        i_rd_valid,
    output logic                        o_wr_en,
    output logic [$clog2(SEGMENTS)-1:0] o_wr_addr,
    output logic [2*ADDRESS_BITS+1:0]   o_wr_data,
    output logic                        o_wr_set_valid,
    output logic                        o_init,
    output logic                        o_push,
    input  logic                        i_res_ready,
    output t_result                     o_res
);

    localparam int AB = ADDRESS_BITS;
    localparam int LW = ADDRESS_BITS + 1;
    localparam int PW = (LW > POOL_W) ? LW : POOL_W;
    localparam int IW = $clog2(SEGMENTS);
    localparam int CW = $clog2(SEGMENTS + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INIT     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_WR_SPARE = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]        r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic [POOL_W-1:0] r_pool;
    logic              r_cmd;
    logic [REQ_W-1:0]  r_size;
    logic [AB-1:0]     r_addr;
    logic              r_best_found;
    logic [IW-1:0]     r_best_idx;
    logic [AB-1:0]     r_best_start;
    logic [LW-1:0]     r_best_len;
    logic              r_spare_found;
    logic [IW-1:0]     r_spare_idx;
    t_result           r_res;

    logic [AB-1:0] e_start;
    logic [LW-1:0] e_len;
    logic          e_use;
    logic          fit;
    logic          better;
    logic          free_hit;
    logic          take_best;
    logic          scan_end;
    logic [PW-1:0] pool_ext;
    logic [PW-1:0] lim;
    logic [LW-1:0] eff_pool;
    logic          exact;
    logic [AB-1:0] carved_start;
    logic [LW-1:0] carved_len;
    logic          dec_wr;
    logic [2*AB+1:0] dec_data;
    logic          need_spare;
    t_result       n_res;

    assign e_start = i_rd_data[2*AB+1 -: AB];
    assign e_len   = i_rd_data[1 +: LW];
    assign e_use   = i_rd_data[0];

    assign fit    = i_rd_valid && !e_use && (PW'(e_len) >= PW'(r_size)) && (r_size != '0);
    assign better = !r_best_found || (e_len < r_best_len) ||
                    ((e_len == r_best_len) && (e_start < r_best_start));
    assign free_hit  = i_rd_valid && e_use && (e_start == r_addr) && !r_best_found;
    assign take_best = r_rd_vld && ((r_cmd == CMD_ALLOC) ? (fit && better) : free_hit);
    assign scan_end  = (r_cnt == CW'(SEGMENTS)) && !r_rd_vld;

    assign pool_ext = PW'(r_pool);
    assign lim      = PW'(1) << AB;
    assign eff_pool = LW'((pool_ext > lim) ? lim : pool_ext);

    assign exact        = (PW'(r_best_len) == PW'(r_size));
    assign carved_start = AB'(PW'(r_best_start) + PW'(r_size));
    assign carved_len   = LW'(PW'(r_best_len) - PW'(r_size));

    // decide the result and the first write-back
    always_comb begin
        n_res      = '{status: ST_OK, granted: '0};
        dec_wr     = 1'b0;
        dec_data   = {r_best_start, r_best_len, 1'b0};
        need_spare = 1'b0;
        if (r_cmd == CMD_ALLOC) begin
            if (!r_best_found) begin
                n_res.status = ST_NO_FIT;
            end else if (exact) begin
                dec_wr        = 1'b1;
                dec_data      = {r_best_start, r_best_len, 1'b1};
                n_res.granted = GRANT_W'(r_best_start);
            end else if (!r_spare_found) begin
                n_res.status = ST_TABLE_FULL;
            end else begin
                dec_wr        = 1'b1;
                dec_data      = {carved_start, carved_len, 1'b0};
                need_spare    = 1'b1;
                n_res.granted = GRANT_W'(r_best_start);
            end
        end else begin
            if (r_best_found) begin
                dec_wr = 1'b1;
            end else begin
                n_res.status = ST_NOT_FOUND;
            end
        end
    end

    assign o_rd_en   = (r_state == S_SCAN) && (r_cnt != CW'(SEGMENTS));
    assign o_rd_addr = r_cnt[IW-1:0];

    always_comb begin
        o_wr_en        = 1'b0;
        o_wr_addr      = r_best_idx;
        o_wr_data      = dec_data;
        o_wr_set_valid = 1'b0;
        o_init         = 1'b0;
        case (r_state)
            S_INIT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = '0;
                o_wr_data = {{AB{1'b0}}, eff_pool, 1'b0};
                o_init    = 1'b1;
            end
            S_DECIDE: begin
                o_wr_en = dec_wr;
            end
            S_WR_SPARE: begin
                o_wr_en        = 1'b1;
                o_wr_addr      = r_spare_idx;
                o_wr_data      = {r_best_start, LW'(r_size), 1'b1};
                o_wr_set_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_push      = (r_state == S_DONE) && i_res_ready;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_pool        <= POOL_RESET;
            r_cnt         <= '0;
            r_rd_vld      <= 1'b0;
            r_best_found  <= 1'b0;
            r_spare_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_pool  <= i_pool_size;
                        r_state <= S_INIT;
                    end else if (i_in_valid) begin
                        r_cnt         <= '0;
                        r_rd_vld      <= 1'b0;
                        r_best_found  <= 1'b0;
                        r_spare_found <= 1'b0;
                        r_state       <= S_SCAN;
                    end
                end
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_rd_vld <= o_rd_en;
                    if (o_rd_en) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (take_best) begin
                        r_best_found <= 1'b1;
                    end
                    if (r_rd_vld && !i_rd_valid && !r_spare_found) begin
                        r_spare_found <= 1'b1;
                    end
                    if (scan_end) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= need_spare ? S_WR_SPARE : S_DONE;
                end
                S_WR_SPARE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_size <= i_request_size;
            r_addr <= AB'(i_free_address);
        end
        if (o_rd_en) begin
            r_rd_idx <= o_rd_addr;
        end
        if (r_state == S_SCAN && take_best) begin
            r_best_idx   <= r_rd_idx;
            r_best_start <= e_start;
            r_best_len   <= e_len;
        end
        if (r_state == S_SCAN && r_rd_vld && !i_rd_valid && !r_spare_found) begin
            r_spare_idx <= r_rd_idx;
        end
        if (r_state == S_DECIDE) begin
            r_res <= n_res;
        end
    end

    a_decide_after_full_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE |-> r_cnt == CW'(SEGMENTS) && !r_rd_vld)
        else $error("decision taken before the scan covered every entry");

    a_spare_follows_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR_SPARE |-> $past(r_state) == S_DECIDE && r_spare_found && r_best_found)
        else $error("spare write without a carved segment");

    a_error_grants_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && r_res.status != ST_OK |-> r_res.granted == '0)
        else $error("failed request carries an address");

endmodule
